[hw/rtl/q2r_pkg.sv]
`default_nettype none

package q2r_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DATA_W     = 18;
    localparam int COMP_W     = DATA_W + 1;          // holds the negated most negative value
    localparam int SQ_W       = 2 * DATA_W;
    localparam int SSQ_W      = SQ_W + 1;
    localparam int ROOT_W     = (SSQ_W + 1) / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int LEN_W      = ROOT_W;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DEN_W      = LEN_W + 1;
    localparam int MAG_W      = DATA_W;
    localparam int NUM_W      = MAG_W + QUO_W + 1;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic signed [SUM_W-1:0] RND_HALF  = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ENTRY_MAX = SUM_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ENTRY_MIN = -SUM_W'(1 << (DATA_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMALIZE = 1'b0,
        CFG_CONJUGATE = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

[hw/rtl/q2r_if.sv]
`default_nettype none

interface q2r_quat_if import q2r_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2r_mat_if import q2r_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
    logic [LEN_W-1:0]         quat_length;
    logic                     zero_length;
    logic                     saturated;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    quat_length, zero_length, saturated, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    quat_length, zero_length, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/q2r_div_lane.sv]
`default_nettype none

// Restoring divider lane: round(|c| * 2^FRAC_BITS / len), sign restored.
// One quotient bit per stage, QUO_W + 1 register stages.
module q2r_div_lane import q2r_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [COMP_W-1:0] i_comp,
    input  logic [LEN_W-1:0]         i_len,
    output logic signed [COMP_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_neg [0:QUO_W];

    logic signed [COMP_W-1:0] n_abs;
    logic [NUM_W-1:0]         n_num;
    logic signed [COMP_W-1:0] n_qval;

    // numerator = 2*mag*2^FRAC_BITS + len, denominator = 2*len
    always_comb begin
        n_abs = (i_comp < 0) ? -i_comp : i_comp;
        n_num = (NUM_W'(n_abs[MAG_W-1:0]) << QUO_W) + NUM_W'(i_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(n_num[NUM_W-1:QUO_W]);
            r_low[0] <= n_num[QUO_W-1:0];
            r_den[0] <= {i_len, 1'b0};
            r_quo[0] <= '0;
            r_neg[0] <= (i_comp < 0);
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic [DEN_W:0] n_trial;
        logic           n_ge;
        always_comb begin
            n_trial = {r_rem[j], r_low[j][QUO_W-1-j]};
            n_ge    = (n_trial >= {1'b0, r_den[j]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= n_ge ? DEN_W'(n_trial - {1'b0, r_den[j]}) : DEN_W'(n_trial);
                r_quo[j+1] <= {r_quo[j][QUO_W-2:0], n_ge};
                r_low[j+1] <= r_low[j];
                r_den[j+1] <= r_den[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    assign n_qval = COMP_W'(r_quo[QUO_W]);
    assign o_quot = r_neg[QUO_W] ? -n_qval : n_qval;

endmodule

`default_nettype wire

[hw/rtl/quaternion_to_rotation_matrix.sv]
// Throughput: one quaternion per cycle; the whole pipeline advances together whenever
// the output register is empty or its result is taken.
// Reset (synchronous, active low): clears all stage valid bits and both configuration
// bits; the datapath registers are not reset.
`default_nettype none

module quaternion_to_rotation_matrix import q2r_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    q2r_quat_if.sink              i_quat,
    q2r_mat_if.source             o_mat
);

    // Stage map (valid bit index):
    //   0            conjugate, squares of the input
    //   1            sum of squares (root stage 0)
    //   2..20        square root, one result bit per stage
    //   21           round the root, decide divide / bypass
    //   22..37       four divider lanes
    //   38           select normalized or raw components
    //   39           ten products
    //   40           nine sums plus rounding offset
    //   41           shift, saturate, output register
    localparam int ST_D   = ROOT_W + 2;
    localparam int ST_E   = ST_D + QUO_W + 2;
    localparam int N_STG  = ST_E + 4;

    typedef struct packed {
        logic                     norm;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] w;
    } t_pay;

    function automatic logic signed [PROD_W-1:0] smul(input logic signed [COMP_W-1:0] a,
                                                      input logic signed [COMP_W-1:0] b);
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    // config
    logic r_norm;
    logic r_conj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b0;
            r_conj <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NORMALIZE: r_norm <= i_cfg_data[0];
                CFG_CONJUGATE: r_conj <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // global advance: every stage moves when the output slot can take a transfer
    logic             n_en;
    logic [N_STG-1:0] r_vld;

    assign n_en         = !r_vld[N_STG-1] || o_mat.ready;
    assign i_quat.ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_quat.valid};
        end
    end

    // stage A: conjugate, squares
    logic signed [DATA_W-1:0] s_in [4];
    logic signed [SQ_W-1:0]   s_ext [4];
    t_pay                     n_a_pay;
    t_pay                     r_a_pay;
    logic [SQ_W-1:0]          r_a_sq [4];

    always_comb begin
        s_in[0] = i_quat.quat_x;
        s_in[1] = i_quat.quat_y;
        s_in[2] = i_quat.quat_z;
        s_in[3] = i_quat.quat_w;
        for (int i = 0; i < 4; i++) begin
            s_ext[i] = s_in[i];
        end
        n_a_pay.norm = r_norm;
        n_a_pay.x    = r_conj ? -COMP_W'(s_in[0]) : COMP_W'(s_in[0]);
        n_a_pay.y    = r_conj ? -COMP_W'(s_in[1]) : COMP_W'(s_in[1]);
        n_a_pay.z    = r_conj ? -COMP_W'(s_in[2]) : COMP_W'(s_in[2]);
        n_a_pay.w    = COMP_W'(s_in[3]);
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_a_pay <= n_a_pay;
            for (int i = 0; i < 4; i++) begin
                r_a_sq[i] <= $unsigned(s_ext[i] * s_ext[i]);
            end
        end
    end

    // stage B + root stages: digit-by-digit square root, two radicand bits per stage
    t_pay                r_sq_pay  [0:ROOT_W];
    logic [2*ROOT_W-1:0] r_sq_ssq  [0:ROOT_W];
    logic [REM_W-1:0]    r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   r_sq_root [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sq_pay[0]  <= r_a_pay;
            r_sq_ssq[0]  <= (2*ROOT_W)'(r_a_sq[0]) + (2*ROOT_W)'(r_a_sq[1])
                          + (2*ROOT_W)'(r_a_sq[2]) + (2*ROOT_W)'(r_a_sq[3]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0] n_trial;
        logic [REM_W-1:0] n_test;
        logic             n_ge;
        always_comb begin
            n_trial = {r_sq_rem[k][REM_W-3:0], r_sq_ssq[k][2*(ROOT_W-1-k) +: 2]};
            n_test  = {r_sq_root[k], 2'b01};
            n_ge    = (n_trial >= n_test);
        end
        always_ff @(posedge i_clk) begin
            if (n_en) begin
                r_sq_pay[k+1]  <= r_sq_pay[k];
                r_sq_ssq[k+1]  <= r_sq_ssq[k];
                r_sq_rem[k+1]  <= n_ge ? n_trial - n_test : n_trial;
                r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], n_ge};
            end
        end
    end

    // stage D: round root to nearest; remainder above root means round up
    logic [LEN_W-1:0] n_len;
    t_pay             r_d_pay;
    logic [LEN_W-1:0] r_d_len;
    logic             r_d_div;
    logic             r_d_zero;

    assign n_len = LEN_W'(r_sq_root[ROOT_W])
                 + LEN_W'(r_sq_rem[ROOT_W] > REM_W'(r_sq_root[ROOT_W]));

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d_pay  <= r_sq_pay[ROOT_W];
            r_d_len  <= n_len;
            r_d_div  <= r_sq_pay[ROOT_W].norm && (n_len != '0);
            r_d_zero <= r_sq_pay[ROOT_W].norm && (n_len == '0);
        end
    end

    // divider lanes, side data delayed alongside
    logic signed [COMP_W-1:0] s_quot [4];
    t_pay                     r_dv_pay  [0:QUO_W];
    logic [LEN_W-1:0]         r_dv_len  [0:QUO_W];
    logic                     r_dv_div  [0:QUO_W];
    logic                     r_dv_zero [0:QUO_W];

    q2r_div_lane u_div_x (.i_clk(i_clk), .i_en(n_en), .i_comp(r_d_pay.x), .i_len(r_d_len),
                          .o_quot(s_quot[0]));
    q2r_div_lane u_div_y (.i_clk(i_clk), .i_en(n_en), .i_comp(r_d_pay.y), .i_len(r_d_len),
                          .o_quot(s_quot[1]));
    q2r_div_lane u_div_z (.i_clk(i_clk), .i_en(n_en), .i_comp(r_d_pay.z), .i_len(r_d_len),
                          .o_quot(s_quot[2]));
    q2r_div_lane u_div_w (.i_clk(i_clk), .i_en(n_en), .i_comp(r_d_pay.w), .i_len(r_d_len),
                          .o_quot(s_quot[3]));

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_dv_pay[0]  <= r_d_pay;
            r_dv_len[0]  <= r_d_len;
            r_dv_div[0]  <= r_d_div;
            r_dv_zero[0] <= r_d_zero;
            for (int j = 0; j < QUO_W; j++) begin
                r_dv_pay[j+1]  <= r_dv_pay[j];
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_div[j+1]  <= r_dv_div[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
            end
        end
    end

    // stage E: normalized components, or raw ones when off / zero length
    logic signed [COMP_W-1:0] r_e_c [4];
    logic [LEN_W-1:0]         r_e_len;
    logic                     r_e_zero;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_e_c[0] <= r_dv_div[QUO_W] ? s_quot[0] : r_dv_pay[QUO_W].x;
            r_e_c[1] <= r_dv_div[QUO_W] ? s_quot[1] : r_dv_pay[QUO_W].y;
            r_e_c[2] <= r_dv_div[QUO_W] ? s_quot[2] : r_dv_pay[QUO_W].z;
            r_e_c[3] <= r_dv_div[QUO_W] ? s_quot[3] : r_dv_pay[QUO_W].w;
            r_e_len  <= r_dv_len[QUO_W];
            r_e_zero <= r_dv_zero[QUO_W];
        end
    end

    // stage F: products xx yy zz ww xy xz yz wx wy wz
    logic signed [PROD_W-1:0] r_f_p [10];
    logic [LEN_W-1:0]         r_f_len;
    logic                     r_f_zero;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_f_p[0] <= smul(r_e_c[0], r_e_c[0]);
            r_f_p[1] <= smul(r_e_c[1], r_e_c[1]);
            r_f_p[2] <= smul(r_e_c[2], r_e_c[2]);
            r_f_p[3] <= smul(r_e_c[3], r_e_c[3]);
            r_f_p[4] <= smul(r_e_c[0], r_e_c[1]);
            r_f_p[5] <= smul(r_e_c[0], r_e_c[2]);
            r_f_p[6] <= smul(r_e_c[1], r_e_c[2]);
            r_f_p[7] <= smul(r_e_c[3], r_e_c[0]);
            r_f_p[8] <= smul(r_e_c[3], r_e_c[1]);
            r_f_p[9] <= smul(r_e_c[3], r_e_c[2]);
            r_f_len  <= r_e_len;
            r_f_zero <= r_e_zero;
        end
    end

    // stage G: exact sums with the half-LSB offset
    logic signed [SUM_W-1:0] s_p [10];
    logic signed [SUM_W-1:0] n_g [9];
    logic signed [SUM_W-1:0] r_g [9];
    logic [LEN_W-1:0]        r_g_len;
    logic                    r_g_zero;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            s_p[i] = r_f_p[i];
        end
        // s_p: 0 xx, 1 yy, 2 zz, 3 ww, 4 xy, 5 xz, 6 yz, 7 wx, 8 wy, 9 wz
        n_g[0] = s_p[3] + s_p[0] - s_p[1] - s_p[2] + RND_HALF;
        n_g[1] = ((s_p[4] - s_p[9]) <<< 1) + RND_HALF;
        n_g[2] = ((s_p[5] + s_p[8]) <<< 1) + RND_HALF;
        n_g[3] = ((s_p[4] + s_p[9]) <<< 1) + RND_HALF;
        n_g[4] = s_p[3] - s_p[0] + s_p[1] - s_p[2] + RND_HALF;
        n_g[5] = ((s_p[6] - s_p[7]) <<< 1) + RND_HALF;
        n_g[6] = ((s_p[5] - s_p[8]) <<< 1) + RND_HALF;
        n_g[7] = ((s_p[6] + s_p[7]) <<< 1) + RND_HALF;
        n_g[8] = s_p[3] - s_p[0] - s_p[1] + s_p[2] + RND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_g      <= n_g;
            r_g_len  <= r_f_len;
            r_g_zero <= r_f_zero;
        end
    end

    // stage H: floor shift (ties went up via the offset), saturate
    logic signed [SUM_W-1:0]  s_sh [9];
    logic signed [DATA_W-1:0] n_m [9];
    logic                     n_sat;
    logic signed [DATA_W-1:0] r_o_m [9];
    logic [LEN_W-1:0]         r_o_len;
    logic                     r_o_zero;
    logic                     r_o_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 9; i++) begin
            s_sh[i] = r_g[i] >>> FRAC_BITS;
            if (s_sh[i] > ENTRY_MAX) begin
                n_m[i] = DATA_W'(ENTRY_MAX);
                n_sat  = 1'b1;
            end else if (s_sh[i] < ENTRY_MIN) begin
                n_m[i] = DATA_W'(ENTRY_MIN);
                n_sat  = 1'b1;
            end else begin
                n_m[i] = DATA_W'(s_sh[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_o_m    <= n_m;
            r_o_len  <= r_g_len;
            r_o_zero <= r_g_zero;
            r_o_sat  <= n_sat;
        end
    end

    assign o_mat.valid       = r_vld[N_STG-1];
    assign o_mat.m00         = r_o_m[0];
    assign o_mat.m01         = r_o_m[1];
    assign o_mat.m02         = r_o_m[2];
    assign o_mat.m10         = r_o_m[3];
    assign o_mat.m11         = r_o_m[4];
    assign o_mat.m12         = r_o_m[5];
    assign o_mat.m20         = r_o_m[6];
    assign o_mat.m21         = r_o_m[7];
    assign o_mat.m22         = r_o_m[8];
    assign o_mat.quat_length = r_o_len;
    assign o_mat.zero_length = r_o_zero;
    assign o_mat.saturated   = r_o_sat;

    // checks
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid && o_mat.zero_length |-> o_mat.quat_length == '0)
        else $error("zero_length with nonzero length");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid |-> o_mat.quat_length <= LEN_W'(1 << (DATA_W)))
        else $error("length above full scale");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_mat.valid |-> i_quat.ready)
        else $error("input stalled with empty output slot");

endmodule

`default_nettype wire
